// File: hdl/lmbs_pkg.sv
`timescale 1ns / 1ps

package lmbs_pkg;

	localparam int ROWS     = 4;
	localparam int COLS     = 12;
	localparam int ROW_W    = 2;
	localparam int COL_W    = 4;
	localparam int IDX_W    = 6;
	localparam int MODE_W   = 2;
	localparam int WORD_W   = 16;
	localparam int CNT_W    = 8;
	localparam int ADDR_W   = 3;
	localparam int DATA_W   = 32;
	localparam int LED_NUM  = ROWS * COLS;

	localparam logic [WORD_W-1:0] ROW_SEL_TOP = {1'b1, {(WORD_W-1){1'b0}}};

	localparam logic [CNT_W-1:0] DUTY_RST   = 8'd8;
	localparam logic [CNT_W-1:0] PERIOD_RST = 8'd16;

	localparam logic CMD_SET  = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	localparam logic [MODE_W-1:0] MODE_OFF    = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ON     = 2'd1;
	localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd2;
	localparam logic [MODE_W-1:0] MODE_SECOND = 2'd3;

	localparam logic REG_DUTY   = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

	typedef struct packed {
		logic [WORD_W-1:0] row_word;
		logic [ROW_W-1:0]  row_number;
		logic              second_phase;
	} rsp_t;

	// row by compare against each row's first index
	function automatic logic [ROW_W-1:0] idx_row(input logic [IDX_W-1:0] idx);
		logic [ROW_W-1:0] row;
		row = '0;
		for (int i = 1; i < ROWS; i++) begin
			if (idx >= IDX_W'(i * COLS)) begin
				row = ROW_W'(i);
			end
		end
		return row;
	endfunction

	function automatic logic [COL_W-1:0] idx_col(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] base;
		base = IDX_W'(idx_row(idx)) * IDX_W'(COLS);
		return COL_W'(idx - base);
	endfunction

endpackage

// File: hdl/lmbs_ifs.sv
`timescale 1ns / 1ps

interface lmbs_req_if;
	logic                         valid;
	logic                         ready;
	logic                         cmd;
	logic [lmbs_pkg::IDX_W-1:0]   led_index;
	logic [lmbs_pkg::MODE_W-1:0]  led_mode;

	modport source (output valid, output cmd, output led_index, output led_mode, input ready);
	modport sink   (input valid, input cmd, input led_index, input led_mode, output ready);
endinterface

interface lmbs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [lmbs_pkg::WORD_W-1:0]  row_word;
	logic [lmbs_pkg::ROW_W-1:0]   row_number;
	logic                         second_phase;

	modport source (output valid, output row_word, output row_number, output second_phase,
		input ready);
	modport sink   (input valid, input row_word, input row_number, input second_phase,
		output ready);
endinterface

// File: hdl/lmbs_ram.sv
`timescale 1ns / 1ps

module lmbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// File: hdl/led_matrix_blink_scanner.sv
`timescale 1ns / 1ps

// LED matrix scanner with two-phase blink.
// req carries requests: cmd = set (led_index, led_mode) or tick. A set updates the
// first- and second-phase dark bitmaps of one row and returns nothing; indexes of 48
// and above are dropped. A tick returns one item on rsp: row_word (one-hot row select
// in bits 15..12, active-low columns in 11..0), row_number and second_phase.
// Both bitmaps share one 4 x 24 RAM. Ticks and in-range sets read it on accept; a set
// writes it in the next cycle, with the last write forwarded to the next request. One
// request per cycle is accepted while req.ready is high. Tick results reach rsp via
// the s1 registers and a 3-entry output queue holding them while rsp.ready is low.
// When a frame ends while blink_count + 1 reaches twice a lowered blink_period, the
// counter is reduced by a bit-serial remainder unit. req.ready drops when the queue
// could overflow or that unit runs. blink_duty and blink_period are APB registers
// at byte addresses 0 and 4. After arst_n every LED reads dark through per-row valid
// bits (no clearing pass), row and blink counter are 0, duty 8 and period 16.

module led_matrix_blink_scanner (
	input  logic                            clk,
	input  logic                            arst_n,
	lmbs_req_if.sink                        req,
	lmbs_rsp_if.source                      rsp,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [lmbs_pkg::ADDR_W-1:0]     paddr,
	input  logic [lmbs_pkg::DATA_W-1:0]     pwdata,
	output logic [lmbs_pkg::DATA_W-1:0]     prdata,
	output logic                            pready
);

	localparam int ENT_W     = 2 * lmbs_pkg::COLS;
	localparam int FIFO_D    = 3;
	localparam int MOD_LAST  = lmbs_pkg::CNT_W;
	localparam logic [lmbs_pkg::COLS-1:0] DARK = {lmbs_pkg::COLS{1'b1}};

	logic [lmbs_pkg::CNT_W-1:0] duty_q;
	logic [lmbs_pkg::CNT_W-1:0] period_q;
	logic [lmbs_pkg::ROW_W-1:0] scan_row_q;
	logic [lmbs_pkg::CNT_W-1:0] blink_count_q;
	logic [lmbs_pkg::ROWS-1:0]  row_valid_q;

	logic                       busy_q;
	logic [lmbs_pkg::CNT_W:0]   mod_n_q;
	logic [lmbs_pkg::CNT_W-1:0] mod_rem_q;
	logic [3:0]                 mod_step_q;

	logic                       valid_s1;
	logic                       tick_s1;
	logic [lmbs_pkg::ROW_W-1:0] row_s1;
	logic [lmbs_pkg::COL_W-1:0] col_s1;
	logic [lmbs_pkg::MODE_W-1:0] mode_s1;
	logic                       second_s1;
	logic                       vbit_s1;

	logic                       fwd_v_q;
	logic [lmbs_pkg::ROW_W-1:0] fwd_row_q;
	logic [ENT_W-1:0]           fwd_data_q;

	lmbs_pkg::rsp_t             fifo_q [FIFO_D];
	logic [1:0]                 cnt_q;

	logic                       cfg_wr;
	logic                       accept;
	logic                       is_tick;
	logic                       in_range;
	logic                       rd_en;
	logic [lmbs_pkg::ROW_W-1:0] rd_addr;
	logic                       second_now;
	logic                       frame_end;
	logic [lmbs_pkg::CNT_W-1:0] per_eff;
	logic [lmbs_pkg::CNT_W:0]   cnt_inc;
	logic [lmbs_pkg::CNT_W:0]   per_dbl;
	logic                       need_mod;
	logic [lmbs_pkg::CNT_W-1:0] cnt_fast;
	logic [lmbs_pkg::CNT_W:0]   mod_shift;
	logic [lmbs_pkg::CNT_W-1:0] mod_next;

	logic [ENT_W-1:0]           ram_rdata;
	logic [ENT_W-1:0]           cur_ent;
	logic [ENT_W-1:0]           new_ent;
	logic [lmbs_pkg::COLS-1:0]  col_bit;
	logic                       lit_first;
	logic                       lit_second;
	logic [lmbs_pkg::COLS-1:0]  first_new;
	logic [lmbs_pkg::COLS-1:0]  second_new;
	logic                       wr_en;
	logic [lmbs_pkg::COLS-1:0]  shown;
	lmbs_pkg::rsp_t             rsp_new;

	logic                       push;
	logic                       pop;
	logic [1:0]                 wr_idx;
	logic                       in_ready;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_comb begin
		prdata = '0;
		case (paddr[2])
			lmbs_pkg::REG_DUTY:   prdata = lmbs_pkg::DATA_W'(duty_q);
			lmbs_pkg::REG_PERIOD: prdata = lmbs_pkg::DATA_W'(period_q);
			default:              prdata = '0;
		endcase
	end

	// accept stage
	assign in_ready  = !busy_q && ((3'(cnt_q) + 3'(push)) < 3'(FIFO_D));
	assign req.ready = in_ready;
	assign accept    = req.valid && in_ready;
	assign is_tick   = (req.cmd == lmbs_pkg::CMD_TICK);
	assign in_range  = (7'(req.led_index) < 7'(lmbs_pkg::LED_NUM));
	assign rd_en     = accept && (is_tick || in_range);
	assign rd_addr   = is_tick ? scan_row_q : lmbs_pkg::idx_row(req.led_index);

	assign second_now = !(blink_count_q < duty_q);
	assign frame_end  = accept && is_tick &&
		(scan_row_q == lmbs_pkg::ROW_W'(lmbs_pkg::ROWS - 1));
	assign per_eff    = (period_q == '0) ? lmbs_pkg::CNT_W'(1) : period_q;
	assign cnt_inc    = {1'b0, blink_count_q} + (lmbs_pkg::CNT_W + 1)'(1);
	assign per_dbl    = {per_eff, 1'b0};
	assign need_mod   = (cnt_inc >= per_dbl);
	assign cnt_fast   = (cnt_inc < {1'b0, per_eff}) ? cnt_inc[lmbs_pkg::CNT_W-1:0] :
		lmbs_pkg::CNT_W'(cnt_inc - {1'b0, per_eff});

	// bit-serial remainder
	assign mod_shift = {mod_rem_q, mod_n_q[lmbs_pkg::CNT_W]};
	assign mod_next  = (mod_shift >= {1'b0, per_eff}) ?
		lmbs_pkg::CNT_W'(mod_shift - {1'b0, per_eff}) : mod_shift[lmbs_pkg::CNT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q        <= lmbs_pkg::DUTY_RST;
			period_q      <= lmbs_pkg::PERIOD_RST;
			scan_row_q    <= '0;
			blink_count_q <= '0;
			busy_q        <= 1'b0;
			mod_step_q    <= '0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					lmbs_pkg::REG_DUTY:   duty_q   <= pwdata[lmbs_pkg::CNT_W-1:0];
					lmbs_pkg::REG_PERIOD: period_q <= pwdata[lmbs_pkg::CNT_W-1:0];
					default: ;
				endcase
			end
			if (accept && is_tick) begin
				scan_row_q <= frame_end ? '0 : scan_row_q + lmbs_pkg::ROW_W'(1);
			end
			if (frame_end) begin
				if (need_mod) begin
					busy_q     <= 1'b1;
					mod_step_q <= '0;
				end else begin
					blink_count_q <= cnt_fast;
				end
			end
			if (busy_q) begin
				mod_step_q <= mod_step_q + 4'd1;
				if (mod_step_q == 4'(MOD_LAST)) begin
					busy_q        <= 1'b0;
					blink_count_q <= mod_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (frame_end && need_mod) begin
			mod_n_q   <= cnt_inc;
			mod_rem_q <= '0;
		end else if (busy_q) begin
			mod_n_q   <= {mod_n_q[lmbs_pkg::CNT_W-1:0], 1'b0};
			mod_rem_q <= mod_next;
		end
	end

	// row bitmap store: second phase in the upper half, first phase in the lower half
	lmbs_ram #(
		.WIDTH (ENT_W),
		.DEPTH (lmbs_pkg::ROWS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (row_s1),
		.wr_data (new_ent),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			fwd_v_q     <= 1'b0;
			row_valid_q <= '0;
		end else begin
			valid_s1 <= rd_en;
			fwd_v_q  <= wr_en;
			if (wr_en) begin
				row_valid_q[row_s1] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			tick_s1   <= is_tick;
			row_s1    <= rd_addr;
			col_s1    <= lmbs_pkg::idx_col(req.led_index);
			mode_s1   <= req.led_mode;
			second_s1 <= second_now;
			vbit_s1   <= row_valid_q[rd_addr];
		end
		if (wr_en) begin
			fwd_row_q  <= row_s1;
			fwd_data_q <= new_ent;
		end
	end

	// modify stage
	always_comb begin
		if (fwd_v_q && (fwd_row_q == row_s1)) begin
			cur_ent = fwd_data_q;
		end else if (vbit_s1) begin
			cur_ent = ram_rdata;
		end else begin
			cur_ent = {DARK, DARK};
		end
	end

	assign col_bit    = lmbs_pkg::COLS'(1) << col_s1;
	assign lit_first  = (mode_s1 == lmbs_pkg::MODE_ON) || (mode_s1 == lmbs_pkg::MODE_FIRST);
	assign lit_second = (mode_s1 == lmbs_pkg::MODE_ON) || (mode_s1 == lmbs_pkg::MODE_SECOND);
	assign first_new  = lit_first ? (cur_ent[lmbs_pkg::COLS-1:0] & ~col_bit) :
		(cur_ent[lmbs_pkg::COLS-1:0] | col_bit);
	assign second_new = lit_second ? (cur_ent[ENT_W-1:lmbs_pkg::COLS] & ~col_bit) :
		(cur_ent[ENT_W-1:lmbs_pkg::COLS] | col_bit);
	assign new_ent    = {second_new, first_new};
	assign wr_en      = valid_s1 && !tick_s1;

	assign shown = second_s1 ? cur_ent[ENT_W-1:lmbs_pkg::COLS] : cur_ent[lmbs_pkg::COLS-1:0];
	assign rsp_new.row_word     = (lmbs_pkg::ROW_SEL_TOP >> row_s1) | lmbs_pkg::WORD_W'(shown);
	assign rsp_new.row_number   = row_s1;
	assign rsp_new.second_phase = second_s1;

	// output queue
	assign push   = valid_s1 && tick_s1;
	assign pop    = (cnt_q != '0) && rsp.ready;
	assign wr_idx = cnt_q - 2'(pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < FIFO_D; i++) begin
			if (push && (wr_idx == 2'(i))) begin
				fifo_q[i] <= rsp_new;
			end else if (pop && (i < FIFO_D - 1)) begin
				fifo_q[i] <= fifo_q[(i < FIFO_D - 1) ? i + 1 : i];
			end
		end
	end

	assign rsp.valid        = (cnt_q != '0);
	assign rsp.row_word     = fifo_q[0].row_word;
	assign rsp.row_number   = fifo_q[0].row_number;
	assign rsp.second_phase = fifo_q[0].second_phase;

endmodule
